>>> hdl/erpm_pkg.sv
// Shared constants, codes and lane status type for the four-wheel speed estimator.
package erpm_pkg;

  localparam int WHEELS = 4;
  localparam int KIND_W = 2;
  localparam int TIME_W = 32;
  localparam int CNT_W  = 32;
  localparam int CPR_W  = 16;
  localparam int RES_W  = 32;

  // Magnitude of a count change fits 33 bits (at most 2^32).
  localparam int MAG_W   = 33;
  // 60000 * 256 = 15360000 needs 24 bits.
  localparam int SCALE_W = 24;
  localparam logic [SCALE_W-1:0] SCALE_Q8 = 24'd15360000;
  localparam int NUM_W   = MAG_W + SCALE_W;
  localparam int DEN_W   = CPR_W + TIME_W;
  localparam int STEP_W  = $clog2(NUM_W);

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PRIME  = 2'd2;

  // What one lane reports to the merge stage.
  typedef struct packed {
    logic             done;
    logic             neg;
    logic             zero;
    logic [NUM_W-1:0] quot;
  } lane_stat_t;

endpackage

>>> hdl/erpm_cfg_if.sv
// Configuration write channel carrying the counts per revolution register.
interface erpm_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] counts_per_rev;

  modport source (output valid, output counts_per_rev, input ready);
  modport sink   (input valid, input counts_per_rev, output ready);
endinterface

>>> hdl/erpm_meas_if.sv
// Input channel carrying one measurement beat: kind, timestamp and four counts.
interface erpm_meas_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [31:0]        time_ms;
  logic signed [31:0] count_front_left;
  logic signed [31:0] count_front_right;
  logic signed [31:0] count_rear_left;
  logic signed [31:0] count_rear_right;

  modport source (output valid, output kind, output time_ms,
                  output count_front_left, output count_front_right,
                  output count_rear_left, output count_rear_right, input ready);
  modport sink   (input valid, input kind, input time_ms,
                  input count_front_left, input count_front_right,
                  input count_rear_left, input count_rear_right, output ready);
endinterface

>>> hdl/erpm_speed_if.sv
// Output channel carrying the four wheel speeds of one sample.
interface erpm_speed_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] rpm_front_left;
  logic signed [31:0] rpm_front_right;
  logic signed [31:0] rpm_rear_left;
  logic signed [31:0] rpm_rear_right;

  modport source (output valid, output rpm_front_left, output rpm_front_right,
                  output rpm_rear_left, output rpm_rear_right, input ready);
  modport sink   (input valid, input rpm_front_left, input rpm_front_right,
                  input rpm_rear_left, input rpm_rear_right, output ready);
endinterface

>>> hdl/encoder_rpm_estimator_4ch.sv
// Top level of the four-wheel encoder speed estimator (M method, Q23.8 RPM).
//
//   Channel  Direction  Handshake          Payload
//   cfg      in         valid/ready        counts_per_rev
//   meas     in         valid/ready        kind, time_ms, four wheel counts
//   speed    out        valid/ready        four wheel speeds, signed Q23.8
//
// A sample beat's count delta is captured on the accepting edge. After that,
// each lane forms the magnitude, does the scaling and denominator multiplies
// and runs the restoring divider, and the merge stage loads the output
// register once all four lanes are done and that register is free. No meas
// beat is taken while a sample is in the lanes; busy clears with that load,
// and the next meas beat can be taken after it.
// Clear, prime and unused kinds finish in the cycle they are accepted.
// Reset is synchronous and active high; it loads counts_per_rev with 1 and
// clears the stored time and counts. The output register lets the next meas
// beat be taken while a result still waits on a stalled speed channel.
module encoder_rpm_estimator_4ch #(
  parameter int COUNT_BITS = 32
) (
  input  logic         clk,
  input  logic         rst,
  erpm_cfg_if.sink     cfg,
  erpm_meas_if.sink    meas,
  erpm_speed_if.source speed
);

  // Configuration register. Writes must arrive only while the block is idle, so
  // the lanes may read it directly while they work; the block does not enforce it.
  logic [erpm_pkg::CPR_W-1:0]  counts_per_rev;

  // Stored time and counts from the last sample, clear or prime beat.
  logic [erpm_pkg::TIME_W-1:0] previous_time;
  logic [erpm_pkg::CNT_W-1:0]  previous_counts [erpm_pkg::WHEELS];

  // Set while a sample is being worked on by the lanes.
  logic                        busy;

  logic                        meas_fire;
  logic                        start;
  logic                        ack;
  logic [erpm_pkg::TIME_W-1:0] dt;
  logic [erpm_pkg::CNT_W-1:0]  cur [erpm_pkg::WHEELS];
  erpm_pkg::lane_stat_t        lane_stat [erpm_pkg::WHEELS];

  assign cfg.ready  = 1'b1;
  assign meas.ready = ~busy;
  assign meas_fire  = meas.valid & meas.ready;
  assign start      = meas_fire & (meas.kind == erpm_pkg::KIND_SAMPLE);

  // Time delta wraps modulo 2^32 just like the timestamp itself.
  assign dt = meas.time_ms - previous_time;

  assign cur[0] = meas.count_front_left;
  assign cur[1] = meas.count_front_right;
  assign cur[2] = meas.count_rear_left;
  assign cur[3] = meas.count_rear_right;

  always_ff @(posedge clk) begin
    if (rst) begin
      counts_per_rev <= erpm_pkg::CPR_W'(1);
    end else if (cfg.valid) begin
      counts_per_rev <= cfg.counts_per_rev;
    end
  end

  // The lanes capture their deltas in the same cycle the beat is accepted,
  // so the stored values can be replaced right away.
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_time <= '0;
      for (int i = 0; i < erpm_pkg::WHEELS; i++) begin
        previous_counts[i] <= '0;
      end
    end else if (meas_fire) begin
      unique case (meas.kind)
        erpm_pkg::KIND_SAMPLE, erpm_pkg::KIND_PRIME: begin
          previous_time <= meas.time_ms;
          for (int i = 0; i < erpm_pkg::WHEELS; i++) begin
            previous_counts[i] <= cur[i];
          end
        end
        erpm_pkg::KIND_CLEAR: begin
          previous_time <= meas.time_ms;
          for (int i = 0; i < erpm_pkg::WHEELS; i++) begin
            previous_counts[i] <= '0;
          end
        end
        default: begin
          // The unused kind leaves all state alone.
        end
      endcase
    end
  end

  // Busy runs from a sample beat until the merge stage moves the four
  // results into the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (ack) begin
      busy <= 1'b0;
    end
  end

  // Four identical lanes, one per wheel, run in lockstep.
  for (genvar w = 0; w < erpm_pkg::WHEELS; w++) begin : g_lane
    erpm_lane #(
      .COUNT_BITS(COUNT_BITS)
    ) u_lane (
      .clk   (clk),
      .rst   (rst),
      .start (start),
      .cur   (cur[w]),
      .prev  (previous_counts[w]),
      .dt    (dt),
      .cpr   (counts_per_rev),
      .ack   (ack),
      .stat  (lane_stat[w])
    );
  end

  erpm_merge u_merge (
    .clk   (clk),
    .rst   (rst),
    .stat  (lane_stat),
    .ack   (ack),
    .speed (speed)
  );

`ifndef NO_ASSERTIONS
  a_lanes_lockstep: assert property (@(posedge clk) disable iff (rst)
    (lane_stat[0].done == lane_stat[1].done) && (lane_stat[0].done == lane_stat[2].done) &&
    (lane_stat[0].done == lane_stat[3].done))
    else $error("lanes finished out of step");

  a_ack_needs_busy: assert property (@(posedge clk) disable iff (rst)
    ack |-> busy)
    else $error("merge loaded results with no sample pending");

  a_start_sets_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> busy && !lane_stat[0].done)
    else $error("sample beat did not start the lanes");

  a_result_from_ack: assert property (@(posedge clk) disable iff (rst)
    $rose(speed.valid) |-> $past(ack))
    else $error("speed beat appeared without a merge load");
`endif

endmodule

>>> hdl/erpm_lane.sv
// One wheel lane: count delta, magnitude, scaling multiply and restoring divider.
module erpm_lane #(
  parameter int COUNT_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [erpm_pkg::CNT_W-1:0]     cur,
  input  logic [erpm_pkg::CNT_W-1:0]     prev,
  input  logic [erpm_pkg::TIME_W-1:0]    dt,
  input  logic [erpm_pkg::CPR_W-1:0]     cpr,
  input  logic                           ack,
  output erpm_pkg::lane_stat_t           stat
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ABS  = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  // Bits kept from the exact difference before it is read back as signed.
  localparam int KB = (COUNT_BITS < 33) ? COUNT_BITS : 33;
  localparam int DW = 34;

  logic [2:0]                      state;
  logic [DW-1:0]                   delta;
  logic [erpm_pkg::TIME_W-1:0]     dt_q;
  logic                            neg;
  logic [erpm_pkg::MAG_W-1:0]      mag;
  logic [erpm_pkg::NUM_W-1:0]      num;
  logic [erpm_pkg::DEN_W-1:0]      den;
  logic [erpm_pkg::DEN_W-1:0]      rem;
  logic [erpm_pkg::STEP_W-1:0]     step;

  logic [32:0]                     diff;
  logic [KB-1:0]                   diff_k;
  logic [DW-1:0]                   delta_next;
  logic [DW-1:0]                   delta_neg;
  logic [erpm_pkg::DEN_W:0]        rem_sh;
  logic [erpm_pkg::DEN_W+1:0]      rem_sub;
  logic                            qbit;

  assign diff       = {cur[erpm_pkg::CNT_W-1], cur} - {prev[erpm_pkg::CNT_W-1], prev};
  assign diff_k     = diff[KB-1:0];
  assign delta_next = {{(DW-KB){diff_k[KB-1]}}, diff_k};
  assign delta_neg  = '0 - delta;

  assign rem_sh  = {rem, num[erpm_pkg::NUM_W-1]};
  assign rem_sub = {1'b0, rem_sh} - {2'b00, den};
  assign qbit    = ~rem_sub[erpm_pkg::DEN_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            delta <= delta_next;
            dt_q  <= dt;
            state <= ST_ABS;
          end
        end
        ST_ABS: begin
          neg   <= delta[DW-1];
          mag   <= delta[DW-1] ? delta_neg[erpm_pkg::MAG_W-1:0] : delta[erpm_pkg::MAG_W-1:0];
          state <= ST_MUL;
        end
        ST_MUL: begin
          num   <= mag * erpm_pkg::SCALE_Q8;
          den   <= cpr * dt_q;
          rem   <= '0;
          step  <= erpm_pkg::STEP_W'(erpm_pkg::NUM_W - 1);
          state <= ST_DIV;
        end
        ST_DIV: begin
          rem  <= qbit ? rem_sub[erpm_pkg::DEN_W-1:0] : rem_sh[erpm_pkg::DEN_W-1:0];
          num  <= {num[erpm_pkg::NUM_W-2:0], qbit};
          step <= step - 1'b1;
          if (step == '0) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (ack) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign stat.done = (state == ST_DONE);
  assign stat.neg  = neg;
  assign stat.zero = (den == '0);
  assign stat.quot = num;

endmodule

>>> hdl/erpm_merge.sv
// Merge stage: saturates the four lane quotients and holds them in the output register.
module erpm_merge (
  input  logic                 clk,
  input  logic                 rst,
  input  erpm_pkg::lane_stat_t stat [erpm_pkg::WHEELS],
  output logic                 ack,
  erpm_speed_if.source         speed
);

  logic [erpm_pkg::RES_W-1:0] rpm [erpm_pkg::WHEELS];
  logic                       all_done;

  function automatic logic [erpm_pkg::RES_W-1:0] saturate(input erpm_pkg::lane_stat_t s);
    logic big;
    big = |s.quot[erpm_pkg::NUM_W-1:erpm_pkg::RES_W-1];
    if (s.zero) begin
      return '0;
    end else if (s.neg) begin
      return big ? {1'b1, {(erpm_pkg::RES_W-1){1'b0}}}
                 : '0 - s.quot[erpm_pkg::RES_W-1:0];
    end else begin
      return big ? {1'b0, {(erpm_pkg::RES_W-1){1'b1}}} : s.quot[erpm_pkg::RES_W-1:0];
    end
  endfunction

  assign all_done = stat[0].done & stat[1].done & stat[2].done & stat[3].done;
  assign ack      = all_done & (~speed.valid | speed.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      speed.valid <= 1'b0;
    end else if (ack) begin
      speed.valid <= 1'b1;
    end else if (speed.ready) begin
      speed.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ack) begin
      for (int i = 0; i < erpm_pkg::WHEELS; i++) begin
        rpm[i] <= saturate(stat[i]);
      end
    end
  end

  assign speed.rpm_front_left  = rpm[0];
  assign speed.rpm_front_right = rpm[1];
  assign speed.rpm_rear_left   = rpm[2];
  assign speed.rpm_rear_right  = rpm[3];

endmodule
